/* src/tfls_pkg.sv */
// Package for the tagged free-list stack: widths, types and function codes.
`default_nettype none
package tfls_pkg;
    localparam int POOL_SLOTS = 1024;
    localparam int SLOT_W     = 10;
    localparam int TAG_W      = 32;
    localparam int CELL_W     = 8;
    localparam int CELL_N     = TAG_W / CELL_W;
    localparam int POOL_AW    = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int ADDR_W     = (POOL_AW > SLOT_W) ? SLOT_W : POOL_AW;
    localparam int MEM_DEPTH  = (POOL_SLOTS > (1 << SLOT_W)) ? (1 << SLOT_W) : POOL_SLOTS;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [TAG_W-1:0]  t_tag;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic {
        FUNC_FREE  = 1'b0,
        FUNC_ALLOC = 1'b1
    } t_func;

    typedef struct packed {
        logic  valid;
        t_slot slot;
    } t_link;

    typedef struct packed {
        t_slot slot_out;
        logic  empty_res;
        t_tag  generation;
    } t_result;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_link wdata;
        logic  re;
        t_addr raddr;
    } t_ram_ctl;

    typedef struct packed {
        logic inc;
        logic carry;
    } t_cell_ctl;
endpackage
`default_nettype wire

/* src/tfls_if.sv */
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface tfls_req_if
    import tfls_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  func;
    t_slot slot_index;

    modport source (output valid, output func, output slot_index, input ready);
    modport sink   (input valid, input func, input slot_index, output ready);
endinterface

interface tfls_rsp_if
    import tfls_pkg::*;
;
    logic  valid;
    logic  ready;
    t_slot slot_out;
    logic  empty_res;
    t_tag  generation;

    modport source (output valid, output slot_out, output empty_res, output generation,
                    input ready);
    modport sink   (input valid, input slot_out, input empty_res, input generation,
                    output ready);
endinterface
`default_nettype wire

/* src/tfls_tag_cell.sv */
// One byte cell of the generation tag counter; carry passes to the next cell.
`default_nettype none
module tfls_tag_cell
    import tfls_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cell_ctl i_ctl,
    output logic      o_carry,
    output t_cell     o_q,
    output t_cell     o_next
);
    t_cell r_q;
    logic [CELL_W:0] w_sum;

    assign w_sum   = {1'b0, r_q} + {{CELL_W{1'b0}}, i_ctl.carry};
    assign o_next  = w_sum[CELL_W-1:0];
    assign o_carry = w_sum[CELL_W];
    assign o_q     = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_ctl.inc) begin
            r_q <= o_next;
        end
    end
endmodule
`default_nettype wire

/* src/tfls_link_ram.sv */
// Per-slot link memory, one write and one registered read port.
`default_nettype none
module tfls_link_ram
    import tfls_pkg::*;
(
    input  wire      i_clk,
    input  t_ram_ctl i_ctl,
    output t_link    o_rdata
);
    t_link r_mem [MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            o_rdata <= r_mem[i_ctl.raddr];
        end
    end
endmodule
`default_nettype wire

/* src/tagged_free_list_stack.sv */
// Top level of the tagged free-list stack allocator.
// A free beat and an allocate on an empty stack load their result when accepted; an
// allocate on a non-empty stack first passes through S_POP, since the new top comes
// from a registered read of the link RAM at the current top. The response register
// and a result stage let a new beat enter while a response waits. The link RAM has no
// clearing pass: every link that is read was written by the free that made its slot
// the top. The 32-bit tag is a row of byte cells chained by their carries.
`default_nettype none
module tagged_free_list_stack
    import tfls_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    tfls_req_if.sink        i_req,
    tfls_rsp_if.source      o_rsp
);
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_POP  = 2'b10
    } t_state;

    t_state  r_state, n_state;
    t_slot   r_top_slot, n_top_slot;
    logic    r_top_valid, n_top_valid;
    logic    r_res_valid, n_res_valid;
    t_result r_res, n_res;
    logic    r_out_valid;
    t_result r_out;

    logic     w_res_move, w_res_free, w_acc, w_in_range, w_top_ok;
    logic     w_push, w_pop_start, w_pop_empty, w_pop_done, w_res_load;
    t_func    w_func;
    t_ram_ctl w_ram_ctl;
    t_link    w_rdata;
    t_tag     w_tag, w_tag_next;
    logic [CELL_N:0] w_carry;

    // tag counter cells
    assign w_carry[0] = 1'b1;
    for (genvar g = 0; g < CELL_N; g++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_ctl.inc   = w_push || w_pop_done;
        assign w_ctl.carry = w_carry[g];
        tfls_tag_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .o_carry (w_carry[g+1]),
            .o_q     (w_tag[g*CELL_W +: CELL_W]),
            .o_next  (w_tag_next[g*CELL_W +: CELL_W])
        );
    end

    tfls_link_ram u_ram (
        .i_clk   (i_clk),
        .i_ctl   (w_ram_ctl),
        .o_rdata (w_rdata)
    );

    assign w_res_move  = r_res_valid && (!r_out_valid || o_rsp.ready);
    assign w_res_free  = !r_res_valid || w_res_move;
    assign i_req.ready = (r_state == S_IDLE) && w_res_free;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_func      = t_func'(i_req.func);
    assign w_in_range  = 32'(i_req.slot_index) < POOL_SLOTS;
    assign w_top_ok    = r_top_valid && (32'(r_top_slot) < POOL_SLOTS);
    assign w_push      = w_acc && (w_func == FUNC_FREE) && w_in_range;
    assign w_pop_start = w_acc && (w_func == FUNC_ALLOC) && w_top_ok;
    assign w_pop_empty = w_acc && (w_func == FUNC_ALLOC) && !w_top_ok;
    assign w_pop_done  = (r_state == S_POP);
    assign w_res_load  = (w_acc && !w_pop_start) || w_pop_done;

    always_comb begin
        w_ram_ctl.we         = w_push;
        w_ram_ctl.waddr      = i_req.slot_index[ADDR_W-1:0];
        w_ram_ctl.wdata.valid = r_top_valid;
        w_ram_ctl.wdata.slot = r_top_valid ? r_top_slot : '0;
        w_ram_ctl.re         = w_pop_start;
        w_ram_ctl.raddr      = r_top_slot[ADDR_W-1:0];
    end

    always_comb begin
        n_state     = r_state;
        n_top_slot  = r_top_slot;
        n_top_valid = r_top_valid;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop_start) begin
                    n_state = S_POP;
                end
                if (w_push) begin
                    n_top_slot  = i_req.slot_index;
                    n_top_valid = 1'b1;
                end
            end
            S_POP: begin
                n_state     = S_IDLE;
                n_top_slot  = w_rdata.slot;
                n_top_valid = w_rdata.valid;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_res_load) begin
            n_res_valid        = 1'b1;
            n_res.slot_out     = w_pop_done ? r_top_slot : '0;
            n_res.empty_res    = w_pop_empty;
            n_res.generation   = (w_push || w_pop_done) ? w_tag_next : w_tag;
        end else if (w_res_move) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_top_slot  <= '0;
            r_top_valid <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top_slot  <= n_top_slot;
            r_top_valid <= n_top_valid;
            r_res_valid <= n_res_valid;
            if (w_res_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_res_move) begin
            r_out <= r_res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.slot_out   = r_out.slot_out;
    assign o_rsp.empty_res  = r_out.empty_res;
    assign o_rsp.generation = r_out.generation;

    a_no_accept_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !i_req.ready)
        else $error("request accepted during link read");

    a_pop_enters_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_func == FUNC_ALLOC && r_top_valid) |=> (r_state == S_POP && !r_res_valid))
        else $error("allocate did not enter link read");

    a_tag_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (w_tag == $past(w_tag) || w_tag == $past(w_tag) + TAG_W'(1)))
        else $error("generation tag moved by more than one");
endmodule
`default_nettype wire
